>>> rtl/rnrw_pkg.sv
// Shared types and constants for the record number replay window block.
`timescale 1ns / 1ps

package rnrw_pkg;

   localparam int WINDOW_BITS_DEF = 64;
   localparam int SEQ_BITS_DEF    = 48;
   localparam int CALC_BITS       = 64;
   localparam int OUT_BITS        = 48;
   localparam int LIMIT_BITS      = 49;
   localparam int COUNT_BITS      = 32;
   localparam int TRUNC_BITS      = 16;
   localparam int BYTES_BITS      = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1) << OUT_BITS;
   localparam logic [BYTES_BITS-1:0] SEQ_BYTES_ONE = BYTES_BITS'(1);

   typedef enum logic {
      ACT_RECONSTRUCT = 1'b0,
      ACT_COMMIT      = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_OVER_LIMIT = 2'd1,
      STATUS_REPLAY     = 2'd2,
      STATUS_AUTH_FAIL  = 2'd3
   } status_type;

   typedef struct packed {
      action_type            action;
      logic [TRUNC_BITS-1:0] truncated_seq;
      logic [BYTES_BITS-1:0] seq_bytes;
      logic [OUT_BITS-1:0]   full_seq;
      logic                  auth_ok;
   } req_item_type;

   typedef struct packed {
      status_type            status;
      logic [COUNT_BITS-1:0] bad_count;
   } commit_result_type;

endpackage

>>> rtl/rnrw_recon.sv
// Reconstruction of a full record number from its truncated form.
`timescale 1ns / 1ps

module rnrw_recon #(
   parameter int SEQ_BITS = rnrw_pkg::SEQ_BITS_DEF
) (
   input  logic [rnrw_pkg::CALC_BITS-1:0]  expected,
   input  logic [rnrw_pkg::TRUNC_BITS-1:0] truncated_seq,
   input  logic [rnrw_pkg::BYTES_BITS-1:0] seq_bytes,
   input  logic [rnrw_pkg::LIMIT_BITS-1:0] seq_limit,
   output logic [rnrw_pkg::CALC_BITS-1:0]  seq,
   output logic                            over_limit
);

   localparam logic [rnrw_pkg::CALC_BITS-1:0] SEQ_MASK =
      {rnrw_pkg::CALC_BITS{1'b1}} >> (rnrw_pkg::CALC_BITS - SEQ_BITS);
   localparam logic [rnrw_pkg::CALC_BITS-1:0] ALL_ONES = {rnrw_pkg::CALC_BITS{1'b1}};

   logic [rnrw_pkg::CALC_BITS-1:0] win;
   logic [rnrw_pkg::CALC_BITS-1:0] half;
   logic [rnrw_pkg::CALC_BITS-1:0] mask;
   logic [rnrw_pkg::CALC_BITS-1:0] cand;
   logic [rnrw_pkg::CALC_BITS-1:0] cand_up;
   logic [rnrw_pkg::CALC_BITS-1:0] cand_dn;
   logic                           low;
   logic                           room;
   logic                           high;

   always_comb begin
      if (seq_bytes == rnrw_pkg::SEQ_BYTES_ONE) begin
         win = rnrw_pkg::CALC_BITS'(256);
      end else begin
         win = rnrw_pkg::CALC_BITS'(65536);
      end
      half = win >> 1;
      mask = win - rnrw_pkg::CALC_BITS'(1);
      cand = (expected & ~mask) | (rnrw_pkg::CALC_BITS'(truncated_seq) & mask);

      // compare against the expected number on both sides in parallel
      low  = (expected >= half) && (cand <= expected - half);
      room = (win <= SEQ_MASK) && (cand <= SEQ_MASK - win);
      high = (expected <= ALL_ONES - half) && (cand >= expected + half);
      cand_up = cand + win;
      cand_dn = cand - win;

      if (low && room) begin
         seq = cand_up;
      end else if (high && (cand >= win)) begin
         seq = cand_dn;
      end else begin
         seq = cand;
      end
      over_limit = (seq > SEQ_MASK) || (seq >= rnrw_pkg::CALC_BITS'(seq_limit));
   end

endmodule

>>> rtl/rnrw_commit.sv
// Replay window state and commit checks: limit, authentication, window.
`timescale 1ns / 1ps

module rnrw_commit #(
   parameter int WINDOW_BITS = rnrw_pkg::WINDOW_BITS_DEF,
   parameter int SEQ_BITS    = rnrw_pkg::SEQ_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              commit_fire,
   input  logic [rnrw_pkg::OUT_BITS-1:0]     full_seq,
   input  logic                              auth_ok,
   input  logic [rnrw_pkg::LIMIT_BITS-1:0]   seq_limit,
   output logic [rnrw_pkg::CALC_BITS-1:0]    expected,
   output logic [rnrw_pkg::COUNT_BITS-1:0]   bad_count,
   output logic [rnrw_pkg::CALC_BITS-1:0]    commit_seq,
   output rnrw_pkg::commit_result_type       commit_res
);

   localparam int SHW = $clog2(WINDOW_BITS);
   localparam logic [rnrw_pkg::CALC_BITS-1:0] SEQ_MASK =
      {rnrw_pkg::CALC_BITS{1'b1}} >> (rnrw_pkg::CALC_BITS - SEQ_BITS);
   localparam logic [rnrw_pkg::CALC_BITS-1:0] WIN_SIZE =
      rnrw_pkg::CALC_BITS'(WINDOW_BITS);
   localparam logic [rnrw_pkg::COUNT_BITS-1:0] COUNT_MAX = {rnrw_pkg::COUNT_BITS{1'b1}};

   logic [SEQ_BITS-1:0]              highest_ff, highest_in;
   logic [WINDOW_BITS-1:0]           window_ff, window_in;
   logic                             any_ff, any_in;
   logic [rnrw_pkg::COUNT_BITS-1:0]  bad_ff, bad_in;
   logic [rnrw_pkg::CALC_BITS-1:0]   expected_ff, expected_in;

   logic [rnrw_pkg::CALC_BITS-1:0]   seq;
   logic [rnrw_pkg::CALC_BITS-1:0]   highest;
   logic [rnrw_pkg::CALC_BITS-1:0]   ahead;
   logic [rnrw_pkg::CALC_BITS-1:0]   behind;
   logic [WINDOW_BITS-1:0]           shifted;
   logic                             over;
   logic                             newer;
   logic                             in_window;
   logic                             seen;
   logic [rnrw_pkg::COUNT_BITS-1:0]  bad_after;

   always_comb begin
      seq       = rnrw_pkg::CALC_BITS'(full_seq) & SEQ_MASK;
      highest   = rnrw_pkg::CALC_BITS'(highest_ff);
      over      = seq >= rnrw_pkg::CALC_BITS'(seq_limit);
      newer     = !any_ff || (seq > highest);
      ahead     = seq - highest;
      behind    = highest - seq;
      in_window = behind < WIN_SIZE;
      seen      = in_window && window_ff[behind[SHW-1:0]];
      if (ahead >= WIN_SIZE) begin
         shifted = '0;
      end else begin
         shifted = window_ff << ahead[SHW-1:0];
      end
      if (bad_ff != COUNT_MAX) begin
         bad_after = bad_ff + rnrw_pkg::COUNT_BITS'(1);
      end else begin
         bad_after = bad_ff;
      end

      highest_in  = highest_ff;
      window_in   = window_ff;
      any_in      = any_ff;
      bad_in      = bad_ff;
      expected_in = expected_ff;
      commit_res.status    = rnrw_pkg::STATUS_OK;
      commit_res.bad_count = bad_ff;

      if (over) begin
         commit_res.status = rnrw_pkg::STATUS_OVER_LIMIT;
      end else if (!auth_ok) begin
         commit_res.status    = rnrw_pkg::STATUS_AUTH_FAIL;
         commit_res.bad_count = bad_after;
         bad_in               = bad_after;
      end else if (newer) begin
         // slide the window forward, or start it fresh on the first number
         if (any_ff) begin
            window_in = shifted;
         end else begin
            window_in = '0;
         end
         window_in[0] = 1'b1;
         highest_in   = SEQ_BITS'(seq);
         any_in       = 1'b1;
         expected_in  = seq + rnrw_pkg::CALC_BITS'(1);
      end else if (!in_window || seen) begin
         commit_res.status = rnrw_pkg::STATUS_REPLAY;
      end else begin
         window_in = window_ff | (WINDOW_BITS'(1) << behind[SHW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff  <= '0;
         window_ff   <= '0;
         any_ff      <= 1'b0;
         bad_ff      <= '0;
         expected_ff <= '0;
      end else if (commit_fire) begin
         highest_ff  <= highest_in;
         window_ff   <= window_in;
         any_ff      <= any_in;
         bad_ff      <= bad_in;
         expected_ff <= expected_in;
      end
   end

   assign expected   = expected_ff;
   assign bad_count  = bad_ff;
   assign commit_seq = seq;

endmodule

>>> rtl/record_number_replay_window_unit.sv
// Top level of the record number replay window block.
`timescale 1ns / 1ps

// Usage:
//   req_ channel: one beat per record. req_action selects reconstruct (rebuild
//   the full number from req_truncated_seq, read only) or commit (check
//   req_full_seq with req_auth_ok against the limit and replay window).
//   rsp_ channel: exactly one beat per request, in request order, carrying the
//   full number, a status code and the failed-authentication count.
//   csr_ channel: writes the 49-bit record number limit; csr_ready is always
//   high. Write it only while no request is in flight.
// Path: a request taken is held in the input register, evaluated from it and
//   registered in the response register, which drives rsp_.
// Throughput: one request per cycle while the response is not stalled. The
//   window state update for a commit lands in the same edge that registers
//   its response, so the very next request already sees it.
// Reset: the window, highest number, seen flag and counter clear, the limit
//   returns to 2^48 and both valid flags drop.
// Stall: while rsp_stall holds the response, the input register keeps one
//   more request; with both full, req_stall rises until the response drains.

module record_number_replay_window_unit #(
   parameter int WINDOW_BITS = rnrw_pkg::WINDOW_BITS_DEF,
   parameter int SEQ_BITS    = rnrw_pkg::SEQ_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [rnrw_pkg::TRUNC_BITS-1:0]   req_truncated_seq,
   input  logic [rnrw_pkg::BYTES_BITS-1:0]   req_seq_bytes,
   input  logic [rnrw_pkg::OUT_BITS-1:0]     req_full_seq,
   input  logic                              req_auth_ok,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rnrw_pkg::OUT_BITS-1:0]     rsp_full_seq_out,
   output logic [1:0]                        rsp_status,
   output logic [rnrw_pkg::COUNT_BITS-1:0]   rsp_bad_count_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rnrw_pkg::LIMIT_BITS-1:0]   csr_seq_limit
);

   rnrw_pkg::req_item_type            req_ff;
   logic                              req_valid_ff, req_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rnrw_pkg::OUT_BITS-1:0]     rsp_seq_ff, rsp_seq_in;
   rnrw_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [rnrw_pkg::COUNT_BITS-1:0]   rsp_bad_ff, rsp_bad_in;
   logic [rnrw_pkg::LIMIT_BITS-1:0]   limit_ff;

   logic                              out_load;
   logic                              advance;
   logic                              req_take;
   logic                              commit_fire;
   logic [rnrw_pkg::CALC_BITS-1:0]    expected;
   logic [rnrw_pkg::COUNT_BITS-1:0]   bad_count;
   logic [rnrw_pkg::CALC_BITS-1:0]    recon_seq;
   logic                              recon_over;
   logic [rnrw_pkg::CALC_BITS-1:0]    commit_seq;
   rnrw_pkg::commit_result_type       commit_res;

   rnrw_recon #(
      .SEQ_BITS (SEQ_BITS)
   ) u_recon (
      .expected      (expected),
      .truncated_seq (req_ff.truncated_seq),
      .seq_bytes     (req_ff.seq_bytes),
      .seq_limit     (limit_ff),
      .seq           (recon_seq),
      .over_limit    (recon_over)
   );

   rnrw_commit #(
      .WINDOW_BITS (WINDOW_BITS),
      .SEQ_BITS    (SEQ_BITS)
   ) u_commit (
      .clock       (clock),
      .reset       (reset),
      .commit_fire (commit_fire),
      .full_seq    (req_ff.full_seq),
      .auth_ok     (req_ff.auth_ok),
      .seq_limit   (limit_ff),
      .expected    (expected),
      .bad_count   (bad_count),
      .commit_seq  (commit_seq),
      .commit_res  (commit_res)
   );

   always_comb begin
      out_load    = !rsp_valid_ff || !rsp_stall;
      advance     = req_valid_ff && out_load;
      req_stall   = req_valid_ff && !out_load;
      req_take    = req_valid && !req_stall;
      commit_fire = advance && (req_ff.action == rnrw_pkg::ACT_COMMIT);

      // hold the input beat until the result register frees up
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (req_ff.action == rnrw_pkg::ACT_COMMIT) begin
         rsp_seq_in    = commit_seq[rnrw_pkg::OUT_BITS-1:0];
         rsp_status_in = commit_res.status;
         rsp_bad_in    = commit_res.bad_count;
      end else begin
         rsp_seq_in = recon_seq[rnrw_pkg::OUT_BITS-1:0];
         if (recon_over) begin
            rsp_status_in = rnrw_pkg::STATUS_OVER_LIMIT;
         end else begin
            rsp_status_in = rnrw_pkg::STATUS_OK;
         end
         rsp_bad_in = bad_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= rnrw_pkg::LIMIT_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_seq_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.action        <= rnrw_pkg::action_type'(req_action);
         req_ff.truncated_seq <= req_truncated_seq;
         req_ff.seq_bytes     <= req_seq_bytes;
         req_ff.full_seq      <= req_full_seq;
         req_ff.auth_ok       <= req_auth_ok;
      end
      if (advance) begin
         rsp_seq_ff    <= rsp_seq_in;
         rsp_status_ff <= rsp_status_in;
         rsp_bad_ff    <= rsp_bad_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_full_seq_out  = rsp_seq_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bad_count_out = rsp_bad_ff;

endmodule

>>> tb/record_number_checker.sv
// Response checker for the record number replay window block: predicts each beat and compares.
`timescale 1ns / 1ps

module record_number_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_action,
   input  logic [rnrw_pkg::TRUNC_BITS-1:0]     req_truncated_seq,
   input  logic [rnrw_pkg::BYTES_BITS-1:0]     req_seq_bytes,
   input  logic [rnrw_pkg::OUT_BITS-1:0]       req_full_seq,
   input  logic                                req_auth_ok,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [rnrw_pkg::OUT_BITS-1:0]       rsp_full_seq_out,
   input  logic [1:0]                          rsp_status,
   input  logic [rnrw_pkg::COUNT_BITS-1:0]     rsp_bad_count_out,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rnrw_pkg::LIMIT_BITS-1:0]     csr_seq_limit,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output logic [3:0][15:0]                    status_tally
);

   localparam int          WIN      = rnrw_pkg::WINDOW_BITS_DEF;
   localparam int          IDX_BITS = $clog2(WIN);
   localparam logic [63:0] SEQ_MAX  = (64'd1 << rnrw_pkg::OUT_BITS) - 64'd1;

   typedef struct packed {
      logic [rnrw_pkg::OUT_BITS-1:0]   seq;
      rnrw_pkg::status_type            status;
      logic [rnrw_pkg::COUNT_BITS-1:0] bad_count;
   } record_result_type;

   record_result_type               predicted_records[$];
   logic [rnrw_pkg::OUT_BITS-1:0]   top_seq;
   logic [WIN-1:0]                  seen_bits;
   logic                            seen_any;
   logic [rnrw_pkg::COUNT_BITS-1:0] auth_failures;
   logic [rnrw_pkg::LIMIT_BITS-1:0] seq_limit;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic limit_hit(input logic [63:0] seq);
      return seq > SEQ_MAX || seq >= 64'(seq_limit);
   endfunction

   // pick the candidate nearest to one past the highest accepted number
   function automatic logic [63:0] rebuild_seq(
      input logic [rnrw_pkg::TRUNC_BITS-1:0] trunc,
      input logic [rnrw_pkg::BYTES_BITS-1:0] nbytes);
      logic [63:0] next_seq, span, half, cand;
      logic        low_side, has_room, high_side;
      next_seq  = seen_any ? 64'(top_seq) + 64'd1 : 64'd0;
      span      = (nbytes == rnrw_pkg::SEQ_BYTES_ONE) ? 64'd256 : 64'd65536;
      half      = span >> 1;
      cand      = (next_seq & ~(span - 64'd1)) | (64'(trunc) & (span - 64'd1));
      low_side  = next_seq >= half && cand <= next_seq - half;
      has_room  = span <= SEQ_MAX && cand <= SEQ_MAX - span;
      high_side = cand >= next_seq + half;
      if (low_side && has_room)
         cand = cand + span;
      else if (high_side && cand >= span)
         cand = cand - span;
      return cand;
   endfunction

   function automatic record_result_type predict_record();
      record_result_type             r;
      logic [63:0]                   seq;
      logic [rnrw_pkg::OUT_BITS-1:0] gap;
      r.status = rnrw_pkg::STATUS_OK;
      if (req_action == rnrw_pkg::ACT_RECONSTRUCT) begin
         seq = rebuild_seq(req_truncated_seq, req_seq_bytes);
         if (limit_hit(seq))
            r.status = rnrw_pkg::STATUS_OVER_LIMIT;
      end else begin
         seq = 64'(req_full_seq);
         if (limit_hit(seq)) begin
            r.status = rnrw_pkg::STATUS_OVER_LIMIT;
         end else if (!req_auth_ok) begin
            if (auth_failures != '1)
               auth_failures = auth_failures + 1'b1;
            r.status = rnrw_pkg::STATUS_AUTH_FAIL;
         end else if (!seen_any || req_full_seq > top_seq) begin
            // slide the window so the new highest number sits in slot 0
            gap = req_full_seq - top_seq;
            if (!seen_any || gap >= rnrw_pkg::OUT_BITS'(WIN))
               seen_bits = '0;
            else
               seen_bits = seen_bits << gap;
            seen_bits[0] = 1'b1;
            top_seq      = req_full_seq;
            seen_any     = 1'b1;
         end else begin
            gap = top_seq - req_full_seq;
            if (gap >= rnrw_pkg::OUT_BITS'(WIN) || seen_bits[gap[IDX_BITS-1:0]])
               r.status = rnrw_pkg::STATUS_REPLAY;
            else
               seen_bits[gap[IDX_BITS-1:0]] = 1'b1;
         end
      end
      r.seq       = seq[rnrw_pkg::OUT_BITS-1:0];
      r.bad_count = auth_failures;
      return r;
   endfunction

   always @(posedge clock) begin
      record_result_type want;
      if (reset) begin
         top_seq       = '0;
         seen_bits     = '0;
         seen_any      = 1'b0;
         auth_failures = '0;
         seq_limit     = rnrw_pkg::LIMIT_RESET;
         predicted_records.delete();
         status_tally  <= '0;
      end else begin
         if (csr_valid && csr_ready)
            seq_limit = csr_seq_limit;
         // retire the response first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (predicted_records.size() == 0) begin
               report_mismatch("response with none outstanding, full_seq_out",
                               64'(rsp_full_seq_out), 64'd0);
            end else begin
               want = predicted_records.pop_front();
               if (rsp_full_seq_out !== want.seq)
                  report_mismatch("full_seq_out", 64'(rsp_full_seq_out), 64'(want.seq));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_bad_count_out !== want.bad_count)
                  report_mismatch("bad_count_out", 64'(rsp_bad_count_out),
                                  64'(want.bad_count));
               status_tally[want.status] <= status_tally[want.status] + 16'd1;
            end
         end
         if (req_valid && !req_stall)
            predicted_records.push_back(predict_record());
      end
      pending_count <= predicted_records.size();
   end

endmodule

>>> tb/tb_record_number_replay_window_unit.sv
// Testbench top for the record number replay window block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_record_number_replay_window_unit;

   localparam logic [rnrw_pkg::OUT_BITS-1:0] SEQ_TOP = '1;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_action;
   logic [rnrw_pkg::TRUNC_BITS-1:0]   req_truncated_seq;
   logic [rnrw_pkg::BYTES_BITS-1:0]   req_seq_bytes;
   logic [rnrw_pkg::OUT_BITS-1:0]     req_full_seq;
   logic                              req_auth_ok;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [rnrw_pkg::OUT_BITS-1:0]     rsp_full_seq_out;
   logic [1:0]                        rsp_status;
   logic [rnrw_pkg::COUNT_BITS-1:0]   rsp_bad_count_out;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [rnrw_pkg::LIMIT_BITS-1:0]   csr_seq_limit;

   int                                mismatch_count;
   int                                pending_count;
   logic [3:0][15:0]                  status_tally;

   int                                sent_beats;
   int                                taken_results;
   logic [rnrw_pkg::OUT_BITS-1:0]     cursor;     // highest number this side expects accepted
   logic [rnrw_pkg::LIMIT_BITS-1:0]   limit_now;

   record_number_replay_window_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_truncated_seq (req_truncated_seq),
      .req_seq_bytes     (req_seq_bytes),
      .req_full_seq      (req_full_seq),
      .req_auth_ok       (req_auth_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_full_seq_out  (rsp_full_seq_out),
      .rsp_status        (rsp_status),
      .rsp_bad_count_out (rsp_bad_count_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_seq_limit     (csr_seq_limit)
   );

   record_number_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_truncated_seq (req_truncated_seq),
      .req_seq_bytes     (req_seq_bytes),
      .req_full_seq      (req_full_seq),
      .req_auth_ok       (req_auth_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_full_seq_out  (rsp_full_seq_out),
      .rsp_status        (rsp_status),
      .rsp_bad_count_out (rsp_bad_count_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_seq_limit     (csr_seq_limit),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .status_tally      (status_tally)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d responses outstanding", pending_count);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [rnrw_pkg::OUT_BITS-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_beat(input rnrw_pkg::action_type act,
                            input logic [rnrw_pkg::TRUNC_BITS-1:0] trunc,
                            input logic [rnrw_pkg::BYTES_BITS-1:0] nbytes,
                            input logic [rnrw_pkg::OUT_BITS-1:0] full, input logic auth);
      int gap;
      // every fourth run of beats goes back to back
      gap = ((sent_beats / 37) % 4 == 3) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_truncated_seq <= trunc;
      req_seq_bytes     <= nbytes;
      req_full_seq      <= full;
      req_auth_ok       <= auth;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent_beats++;
      if (act == rnrw_pkg::ACT_COMMIT && auth && 49'(full) < limit_now && full > cursor)
         cursor = full;
   endtask

   task automatic rebuild_beat(input logic [rnrw_pkg::TRUNC_BITS-1:0] trunc,
                               input logic [rnrw_pkg::BYTES_BITS-1:0] nbytes);
      send_beat(rnrw_pkg::ACT_RECONSTRUCT, trunc, nbytes, rand48(), 1'($urandom));
   endtask

   task automatic commit_beat(input logic [rnrw_pkg::OUT_BITS-1:0] full, input logic auth);
      send_beat(rnrw_pkg::ACT_COMMIT, 16'($urandom), 2'($urandom), full, auth);
   endtask

   task automatic write_limit(input logic [rnrw_pkg::LIMIT_BITS-1:0] value);
      csr_valid     <= 1'b1;
      csr_seq_limit <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      limit_now = value;
   endtask

   // drop valid and wait out every outstanding response plus the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_records(input int count);
      int                            kind;
      int                            step;
      logic [rnrw_pkg::OUT_BITS-1:0] full;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            full = cursor + 48'($urandom_range(0, 600)) - 48'd300;
            rebuild_beat(full[rnrw_pkg::TRUNC_BITS-1:0], 2'($urandom_range(0, 3)));
         end else if (kind < 30) begin
            rebuild_beat(16'($urandom), 2'($urandom_range(0, 3)));
         end else if (kind < 58 || (kind >= 93 && limit_now > 49'(SEQ_TOP))) begin
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 130)
                                               : $urandom_range(1, 12);
            full = (cursor > SEQ_TOP - 48'(step)) ? SEQ_TOP : cursor + 48'(step);
            commit_beat(full, 1'b1);
         end else if (kind < 80) begin
            step = $urandom_range(0, 70);
            full = (cursor >= 48'(step)) ? cursor - 48'(step) : '0;
            commit_beat(full, 1'b1);
         end else if (kind < 90) begin
            commit_beat(cursor - 48'($urandom_range(0, 5)), 1'b0);
         end else if (kind < 93) begin
            commit_beat(rand48(), 1'($urandom));
         end else begin
            // probe right at the limit
            commit_beat(limit_now[rnrw_pkg::OUT_BITS-1:0] - 48'($urandom_range(0, 2)), 1'b1);
         end
      end
   endtask

   initial begin : drain_responses
      int hold;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         // long hold-offs let the block fill and push back on the sender
         if (taken_results == 200 || taken_results == 800)
            hold = 50;
         else if ((taken_results / 41) % 4 == 2)
            hold = 0;
         else
            hold = $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken_results++;
      end
   end

   initial begin : make_stimulus
      logic [rnrw_pkg::LIMIT_BITS-1:0] tight;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= rnrw_pkg::ACT_RECONSTRUCT;
      req_truncated_seq <= '0;
      req_seq_bytes     <= '0;
      req_full_seq      <= '0;
      req_auth_ok       <= 1'b0;
      csr_valid         <= 1'b0;
      csr_seq_limit     <= rnrw_pkg::LIMIT_RESET;
      cursor        = '0;
      limit_now     = rnrw_pkg::LIMIT_RESET;
      sent_beats    = 0;
      taken_results = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // limit at its reset value
      rebuild_beat(16'h0000, rnrw_pkg::SEQ_BYTES_ONE);
      rebuild_beat(16'hFFFF, 2'd2);
      rebuild_beat(16'h00FF, 2'd0);
      rebuild_beat(16'hAB80, 2'd3);
      commit_beat(48'd5, 1'b0);
      commit_beat(48'd5, 1'b1);
      commit_beat(48'd5, 1'b1);
      commit_beat(48'd3, 1'b1);
      commit_beat(48'd3, 1'b1);
      commit_beat(48'd68, 1'b1);      // slide by 63: number 5 lands in the oldest slot
      commit_beat(48'd5, 1'b1);
      commit_beat(48'd4, 1'b1);       // one past the oldest slot
      commit_beat(48'h1F0, 1'b1);     // slide past the whole window
      rebuild_beat(16'h0005, rnrw_pkg::SEQ_BYTES_ONE);
      rebuild_beat(16'h0000, 2'd2);
      commit_beat(SEQ_TOP, 1'b0);
      random_records(280);
      settle();

      // limit just above the current highest number
      tight = 49'(cursor) + 49'($urandom_range(20, 150));
      write_limit(tight);
      commit_beat(tight[rnrw_pkg::OUT_BITS-1:0], 1'b1);
      commit_beat(tight[rnrw_pkg::OUT_BITS-1:0], 1'b0);
      commit_beat(tight[rnrw_pkg::OUT_BITS-1:0] - 48'd1, 1'b1);
      rebuild_beat(tight[rnrw_pkg::TRUNC_BITS-1:0], 2'd2);
      random_records(200);
      settle();

      write_limit('0);
      commit_beat('0, 1'b1);
      random_records(60);
      settle();

      write_limit('1);
      random_records(250);
      settle();

      write_limit({17'($urandom), 32'($urandom)});
      random_records(100);
      settle();

      // top of the number space
      write_limit(rnrw_pkg::LIMIT_RESET);
      commit_beat(SEQ_TOP - 48'd200, 1'b1);
      commit_beat(SEQ_TOP, 1'b1);
      rebuild_beat(16'h0000, 2'd2);
      rebuild_beat(16'hFFFF, 2'd2);
      rebuild_beat(16'h0040, rnrw_pkg::SEQ_BYTES_ONE);
      commit_beat(SEQ_TOP, 1'b1);
      commit_beat(SEQ_TOP - 48'd1, 1'b1);
      random_records(200);
      settle();

      $display("Sent %0d records through six limit settings, from zero and a tight bound",
               sent_beats);
      $display("to all ones and the top of the number space");
      $display("Checked: %0d accepted, %0d over limit, %0d replayed or stale, %0d auth failed",
               status_tally[rnrw_pkg::STATUS_OK], status_tally[rnrw_pkg::STATUS_OVER_LIMIT],
               status_tally[rnrw_pkg::STATUS_REPLAY], status_tally[rnrw_pkg::STATUS_AUTH_FAIL]);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
